// ----- sv/csvp_pkg.sv -----
// ----------------------------------------------------------------------------
// csvp_pkg
// Shared constants and types for the CSV byte stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csvp_pkg;

  // Limits of the document and the cell store
  localparam int unsigned MAX_ROWS   = 1024;
  localparam int unsigned MAX_COLS   = 64;
  localparam int unsigned CELL_BYTES = 256;

  // Widths of the running state
  localparam int unsigned ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int unsigned COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned OFF_W  = $clog2(CELL_BYTES);
  localparam int unsigned WIDE_W = $clog2(MAX_COLS + 1);

  // Fixed widths of the result fields
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned RIDX_W  = 10;
  localparam int unsigned CIDX_W  = 6;
  localparam int unsigned COFF_W  = 8;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RCNT_W  = 11;
  localparam int unsigned CCNT_W  = 7;

  // Special characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR     = 2'd0,
    KIND_CELL_END = 2'd1,
    KIND_ROW_END  = 2'd2,
    KIND_DOC_END  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [RIDX_W-1:0] row_index;
    logic [CIDX_W-1:0] column_index;
    logic [COFF_W-1:0] char_offset;
    logic [CHAR_W-1:0] cell_char;
    logic [RCNT_W-1:0] row_count;
    logic [CCNT_W-1:0] column_count;
    logic              last_result;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/csv_byte_stream_parser.sv -----
// ----------------------------------------------------------------------------
// csv_byte_stream_parser
// Streaming CSV tokeniser: cell characters and cell, row and document events.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one word per text byte: tdata = byte, tuser = byte valid
//   flag (0 for an end-only word), tlast = end of document after this byte.
//   Master side gives one word per result: tuser = kind (character, end of
//   cell, end of cell and row, end of document), tdata = row, column, offset,
//   character, row count and widest row, tlast = last result of the word in.
//   The result queue registers each result before it is offered.
//   Throughput: one byte per cycle while each byte gives at most one result
//   and the receiver keeps tready high; a byte that also ends the document
//   gives two results when it yields a result of its own. The rate is set by the
//   single output port of the four-entry result queue.
//   s_axis_tready_o is high while the queue has room for two results, so a
//   byte is still taken while an earlier result waits to be read.
//   When the receiver stalls, results stay queued and tdata holds steady;
//   once the queue holds three or more results the slave side stalls too.
//   Reset: quote state, row, column, offset and widest-row counters clear,
//   the queue empties; the block is ready for a new document at once.
//   After an end of document all parse state returns to its reset value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csv_byte_stream_parser
  import csvp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  wire logic        s_axis_tuser_i,   // [0] byte_valid
  input  wire logic        s_axis_tlast_i,   // end_of_text
  // master side
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [9:0] row_index, [15:10] column_index, [23:16] char_offset,
  // [31:24] cell_char, [42:32] row_count, [49:43] column_count, [55:50] zero
  output      logic [55:0] m_axis_tdata_o,
  output      logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output      logic        m_axis_tlast_o    // last_result
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Parse state
  logic              in_quote_q, in_quote_d;
  logic              quote_pending_q, quote_pending_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [WIDE_W-1:0] wide_q, wide_d;

  // Result queue
  result_t           queue_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  logic       accept, pop;
  logic       active, plain, store;
  logic [7:0] store_char, b;
  logic       byte_res;   // a result comes from the byte itself
  result_t    res_byte, res_end, ent0, ent1;
  logic       push0, push1;
  logic [WIDE_W-1:0] cols_end;
  logic [ROW_W-1:0]  rows_end;

  assign b               = s_axis_tdata_i;
  assign s_axis_tready_o = (count_q <= QCNT_W'(QDEPTH - 2));
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign active          = s_axis_tuser_i && (row_q < ROW_W'(MAX_ROWS));

  // Byte decode and state update
  always_comb begin
    in_quote_d      = in_quote_q;
    quote_pending_d = quote_pending_q;
    row_d           = row_q;
    col_d           = col_q;
    off_d           = off_q;
    wide_d          = wide_q;
    plain           = 1'b0;
    store           = 1'b0;
    store_char      = b;
    byte_res        = 1'b0;
    res_byte        = '0;
    res_end         = '0;
    cols_end        = '0;
    rows_end        = '0;

    res_byte.row_index    = RIDX_W'(row_q);
    res_byte.column_index = CIDX_W'(col_q);
    res_byte.char_offset  = COFF_W'(off_q);

    if (active) begin
      if (quote_pending_q) begin
        quote_pending_d = 1'b0;
        if (b == CH_QUOTE) begin
          store = 1'b1;
        end else begin
          in_quote_d = 1'b0;
          plain      = 1'b1;
        end
      end else if (in_quote_q) begin
        if (b == CH_QUOTE) quote_pending_d = 1'b1;
        else               store           = 1'b1;
      end else begin
        plain = 1'b1;
      end
    end

    if (plain) begin
      unique case (b)
        CH_QUOTE: in_quote_d = 1'b1;
        CH_COMMA: begin
          byte_res      = 1'b1;
          res_byte.kind = KIND_CELL_END;
          if (col_q != COL_W'(MAX_COLS - 1)) col_d = col_q + 1'b1;
          off_d = '0;
        end
        CH_LF: begin
          byte_res      = 1'b1;
          res_byte.kind = KIND_ROW_END;
          if (WIDE_W'(col_q) + 1'b1 > wide_q) wide_d = WIDE_W'(col_q) + 1'b1;
          col_d = '0;
          off_d = '0;
          row_d = row_q + 1'b1;
        end
        CH_CR: ;
        default: store = 1'b1;
      endcase
    end

    // cell full: character dropped without a result
    if (store && (off_q < OFF_W'(CELL_BYTES - 1))) begin
      byte_res           = 1'b1;
      res_byte.kind      = KIND_CHAR;
      res_byte.cell_char = store_char;
      off_d              = off_q + 1'b1;
    end

    if (!byte_res) res_byte = '0;
    res_byte.last_result = byte_res & ~s_axis_tlast_i;

    // end of document: summary from the updated state, then back to reset
    if (s_axis_tlast_i) begin
      cols_end = WIDE_W'(col_d) + 1'b1;
      if (wide_d > cols_end) cols_end = wide_d;
      rows_end = (row_d >= ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : row_d + 1'b1;
      res_end.kind         = KIND_DOC_END;
      res_end.row_count    = RCNT_W'(rows_end);
      res_end.column_count = CCNT_W'(cols_end);
      res_end.last_result  = 1'b1;
      in_quote_d      = 1'b0;
      quote_pending_d = 1'b0;
      row_d           = '0;
      col_d           = '0;
      off_d           = '0;
      wide_d          = '0;
    end
  end

  // queue write selection
  always_comb begin
    push0 = 1'b0;
    push1 = 1'b0;
    ent0  = res_byte;
    ent1  = res_end;
    if (accept) begin
      if (byte_res) begin
        push0 = 1'b1;
        push1 = s_axis_tlast_i;
      end else if (s_axis_tlast_i) begin
        push0 = 1'b1;
        ent0  = res_end;
      end
    end
  end

  assign pop = m_axis_tvalid_o & m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quote_q      <= 1'b0;
      quote_pending_q <= 1'b0;
      row_q           <= '0;
      col_q           <= '0;
      off_q           <= '0;
      wide_q          <= '0;
      wr_ptr_q        <= '0;
      rd_ptr_q        <= '0;
      count_q         <= '0;
    end else begin
      if (accept) begin
        in_quote_q      <= in_quote_d;
        quote_pending_q <= quote_pending_d;
        row_q           <= row_d;
        col_q           <= col_d;
        off_q           <= off_d;
        wide_q          <= wide_d;
      end
      wr_ptr_q <= wr_ptr_q + QPTR_W'(push0) + QPTR_W'(push1);
      rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
      count_q  <= count_q + QCNT_W'(push0) + QCNT_W'(push1) - QCNT_W'(pop);
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push0) queue_q[wr_ptr_q] <= ent0;
    if (push1) queue_q[wr_ptr_q + 1'b1] <= ent1;
  end

  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tuser_o  = queue_q[rd_ptr_q].kind;
  assign m_axis_tlast_o  = queue_q[rd_ptr_q].last_result;
  assign m_axis_tdata_o  = {6'd0,
                            queue_q[rd_ptr_q].column_count,
                            queue_q[rd_ptr_q].row_count,
                            queue_q[rd_ptr_q].cell_char,
                            queue_q[rd_ptr_q].char_offset,
                            queue_q[rd_ptr_q].column_index,
                            queue_q[rd_ptr_q].row_index};

endmodule

`default_nettype wire
